[rtl/mi3_pkg.sv]
// mi3_pkg: widths, types and the shared control struct for the 3x3 matrix inverse.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package mi3_pkg;

  // element format: signed fixed point, ELEM_W bits with FRAC_W fraction bits
  localparam int ELEM_W = 32;
  localparam int FRAC_W = 16;
  localparam int NUM_EL = 9;

  // derived widths
  localparam int PROD_W = 2 * ELEM_W;          // one element product
  localparam int COF_W  = 2 * ELEM_W + 1;      // signed cofactor
  localparam int CMAG_W = 2 * ELEM_W;          // cofactor magnitude
  localparam int DET_W  = 3 * ELEM_W + 1;      // signed determinant
  localparam int DMAG_W = 3 * ELEM_W;          // determinant magnitude
  localparam int DIVD_W = DMAG_W + 1;          // divisor, twice the magnitude
  localparam int NUM_W  = 4 * ELEM_W + 2 * FRAC_W + 2; // dividend and remainder
  localparam int WORD_W = NUM_EL * ELEM_W;
  localparam int TDATA_W = ((WORD_W + 7) / 8) * 8;
  localparam int TUSER_W = 8;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic        [CMAG_W-1:0] cmag_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic        [DMAG_W-1:0] dmag_t;

  // determinant summary handed to the dividers
  typedef struct packed {
    dmag_t mag;
    logic  neg;
    logic  sing;
  } det_info_t;

endpackage

[rtl/mi3_cofactor.sv]
// mi3_cofactor: two register stages, element products then cofactors.
// Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_cofactor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  mi3_pkg::elem_t    a_i [mi3_pkg::NUM_EL],
  output logic              valid_o,
  output mi3_pkg::elem_t    row0_o [3],
  output mi3_pkg::cof_t     cof_o [mi3_pkg::NUM_EL]
);

  mi3_pkg::prod_t p1_q [mi3_pkg::NUM_EL];
  mi3_pkg::prod_t p2_q [mi3_pkg::NUM_EL];
  mi3_pkg::elem_t row0_s1_q [3];
  mi3_pkg::elem_t row0_q [3];
  mi3_pkg::cof_t  cof_q [mi3_pkg::NUM_EL];
  logic           v1_q, v2_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // stage 1: products of the minors; input words are stored by column
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p1_q[r*3+c] <= a_i[((c+1)%3)*3 + (r+1)%3] * a_i[((c+2)%3)*3 + (r+2)%3];
          p2_q[r*3+c] <= a_i[((c+2)%3)*3 + (r+1)%3] * a_i[((c+1)%3)*3 + (r+2)%3];
        end
      end
      for (int c = 0; c < 3; c++) row0_s1_q[c] <= a_i[c*3];
    end
  end

  // stage 2: cofactor = difference of the two products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < mi3_pkg::NUM_EL; k++) begin
        cof_q[k] <= mi3_pkg::COF_W'(p1_q[k]) - mi3_pkg::COF_W'(p2_q[k]);
      end
      row0_q <= row0_s1_q;
    end
  end

  assign valid_o = v2_q;
  assign row0_o  = row0_q;
  assign cof_o   = cof_q;

endmodule

[rtl/mi3_det.sv]
// mi3_det: four register stages forming the determinant along the first row,
// plus cofactor magnitudes and signs. Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_det (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  mi3_pkg::elem_t      row0_i [3],
  input  mi3_pkg::cof_t       cof_i [mi3_pkg::NUM_EL],
  output logic                valid_o,
  output mi3_pkg::cmag_t      cmag_o [mi3_pkg::NUM_EL],
  output logic                cneg_o [mi3_pkg::NUM_EL],
  output mi3_pkg::det_info_t  det_o
);

  localparam int PP_W = 2 * mi3_pkg::ELEM_W + 1;
  localparam int HI_W = mi3_pkg::COF_W - mi3_pkg::ELEM_W;

  logic signed [PP_W-1:0] lo_q [3];
  logic signed [PP_W-1:0] hi_q [3];
  mi3_pkg::det_t          term_q [3];
  mi3_pkg::det_t          det_q;
  mi3_pkg::det_t          det_neg;
  mi3_pkg::det_info_t     info_q;

  mi3_pkg::cof_t  cof_neg [mi3_pkg::NUM_EL];
  mi3_pkg::cmag_t cmag_c [mi3_pkg::NUM_EL];
  mi3_pkg::cmag_t cmag3_q [mi3_pkg::NUM_EL];
  mi3_pkg::cmag_t cmag4_q [mi3_pkg::NUM_EL];
  mi3_pkg::cmag_t cmag5_q [mi3_pkg::NUM_EL];
  mi3_pkg::cmag_t cmag6_q [mi3_pkg::NUM_EL];
  logic           cneg3_q [mi3_pkg::NUM_EL];
  logic           cneg4_q [mi3_pkg::NUM_EL];
  logic           cneg5_q [mi3_pkg::NUM_EL];
  logic           cneg6_q [mi3_pkg::NUM_EL];
  logic           v3_q, v4_q, v5_q, v6_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // cofactor magnitude
  always_comb begin
    for (int k = 0; k < mi3_pkg::NUM_EL; k++) begin
      cof_neg[k] = -cof_i[k];
      cmag_c[k]  = cof_i[k][mi3_pkg::COF_W-1] ? cof_neg[k][mi3_pkg::CMAG_W-1:0]
                                              : cof_i[k][mi3_pkg::CMAG_W-1:0];
    end
  end

  // stage 3: split the wide cofactor into two partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        lo_q[c] <= row0_i[c] * $signed({1'b0, cof_i[c][mi3_pkg::ELEM_W-1:0]});
        hi_q[c] <= row0_i[c] *
                   $signed(cof_i[c][mi3_pkg::COF_W-1:mi3_pkg::COF_W-HI_W]);
      end
      for (int k = 0; k < mi3_pkg::NUM_EL; k++) begin
        cmag3_q[k] <= cmag_c[k];
        cneg3_q[k] <= cof_i[k][mi3_pkg::COF_W-1];
      end
    end
  end

  // stage 4: recombine partial products into each term
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        term_q[c] <= (mi3_pkg::DET_W'(hi_q[c]) <<< mi3_pkg::ELEM_W) +
                     mi3_pkg::DET_W'(lo_q[c]);
      end
      cmag4_q <= cmag3_q;
      cneg4_q <= cneg3_q;
    end
  end

  // stage 5: determinant
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q   <= term_q[0] + term_q[1] + term_q[2];
      cmag5_q <= cmag4_q;
      cneg5_q <= cneg4_q;
    end
  end

  assign det_neg = -det_q;

  // stage 6: sign, magnitude and zero test
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      info_q.neg  <= det_q[mi3_pkg::DET_W-1];
      info_q.mag  <= det_q[mi3_pkg::DET_W-1] ? det_neg[mi3_pkg::DMAG_W-1:0]
                                             : det_q[mi3_pkg::DMAG_W-1:0];
      info_q.sing <= (det_q == '0);
      cmag6_q     <= cmag5_q;
      cneg6_q     <= cneg5_q;
    end
  end

  assign valid_o = v6_q;
  assign cmag_o  = cmag6_q;
  assign cneg_o  = cneg6_q;
  assign det_o   = info_q;

endmodule

[rtl/mi3_div.sv]
// mi3_div: pipelined restoring divider for one inverse element, one quotient
// bit per stage, with rounding, saturation and the singular case. Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  mi3_pkg::cmag_t      cmag_i,
  input  logic                cneg_i,
  input  mi3_pkg::det_info_t  det_i,
  output logic                valid_o,
  output mi3_pkg::elem_t      q_o,
  output logic                sat_o,
  output logic                sing_o
);

  localparam int EW = mi3_pkg::ELEM_W;
  localparam int NW = mi3_pkg::NUM_W;
  localparam int DV = mi3_pkg::DIVD_W;

  // stage A: dividend and divisor
  logic [NW-1:0] n_q;
  logic [DV-1:0] da_q;
  logic          nega_q, singa_q, va_q;

  // bit stages share these arrays; entry 0 is written by the overflow stage
  logic [NW-1:0] r_q    [EW+1];
  logic [DV-1:0] d_q    [EW+1];
  logic [EW-1:0] q_q    [EW+1];
  logic          neg_q  [EW+1];
  logic          sing_q [EW+1];
  logic          ovf_q  [EW+1];
  logic          v_q    [EW+1];

  // output stage
  logic          neg_eff;
  logic [EW:0]   lim;
  logic          over;
  logic [EW-1:0] qs;
  mi3_pkg::elem_t res_q;
  logic          sat_q, sing_out_q, vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  // dividend 2|C|*2^(2F) + |det|, divisor 2|det|: quotient rounds half away
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q     <= (NW'(cmag_i) << (2 * mi3_pkg::FRAC_W + 1)) + NW'(det_i.mag);
      da_q    <= {det_i.mag, 1'b0};
      nega_q  <= cneg_i ^ det_i.neg;
      singa_q <= det_i.sing;
    end
  end

  // overflow stage: quotient of 2^EW or more saturates whatever the sign
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= n_q;
      d_q[0]    <= da_q;
      q_q[0]    <= '0;
      neg_q[0]  <= nega_q;
      sing_q[0] <= singa_q;
      ovf_q[0]  <= (n_q >= (NW'(da_q) << EW));
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < EW; k++) begin : g_bit
    localparam int B = EW - 1 - k;
    logic [NW:0] diff;

    assign diff = {1'b0, r_q[k]} - ({1'b0, NW'(d_q[k])} << B);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]    <= diff[NW] ? r_q[k] : diff[NW-1:0];
        q_q[k+1]    <= diff[NW] ? q_q[k] : (q_q[k] | (EW'(1) << B));
        d_q[k+1]    <= d_q[k];
        neg_q[k+1]  <= neg_q[k];
        sing_q[k+1] <= sing_q[k];
        ovf_q[k+1]  <= ovf_q[k];
      end
    end
  end

  // clamp against the signed limit, then apply the sign
  always_comb begin
    neg_eff = neg_q[EW] & (ovf_q[EW] | (q_q[EW] != '0));
    lim     = (EW+1)'(1) << (EW - 1);
    if (!neg_eff) lim = lim - (EW+1)'(1);
    over    = ovf_q[EW] | ({1'b0, q_q[EW]} > lim);
    qs      = over ? lim[EW-1:0] : q_q[EW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[EW];
    end
  end

  // singular matrix: zero result, no clamp flag
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (sing_q[EW]) begin
        res_q <= '0;
        sat_q <= 1'b0;
      end else begin
        res_q <= neg_eff ? $signed(-qs) : $signed(qs);
        sat_q <= over;
      end
      sing_out_q <= sing_q[EW];
    end
  end

  assign valid_o = vo_q;
  assign q_o     = res_q;
  assign sat_o   = sat_q;
  assign sing_o  = sing_out_q;

endmodule

[rtl/matrix3x3_inverse.sv]
// matrix3x3_inverse: top level; cofactor, determinant and divider pipelines
// with a two-word output buffer. Depends on mi3_pkg and the mi3_* modules.
`timescale 1ns / 1ps
//
// Usage
//   Slave stream takes one matrix per word: nine signed Q16.16 elements by
//   column, col0_row0 in the lowest 32 bits. Master stream returns the inverse
//   in the same order in tdata, with tuser[0] = singular, tuser[1] = saturated.
//   A zero determinant gives an all-zero inverse with singular set.
// Pipeline: 2 cofactor stages, 4 determinant stages, 35 divider stages
//   (one per quotient bit plus set-up, overflow and clamp stages) and the
//   output register lie between an accepted input word and m_axis_tvalid.
// Throughput: one matrix per cycle unless stalled; each divider bit stage is
//   one wide subtract and compare, so every stage takes a new word each cycle.
// Stall: the output register plus a skid register let one more word finish
//   while a result waits; the whole pipeline holds once the skid is full and
//   s_axis_tready drops. Nothing is lost or repeated.
// Reset: clears every valid bit; no result is pending afterwards.
//
module matrix3x3_inverse (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // col0_row0, col0_row1, col0_row2, col1_row0 .. col2_row2, 32 bits each
  input  logic [mi3_pkg::TDATA_W-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // inv_col0_row0, inv_col0_row1 .. inv_col2_row2, 32 bits each
  output logic [mi3_pkg::TDATA_W-1:0]  m_axis_tdata,
  // singular, saturated, then zero fill
  output logic [mi3_pkg::TUSER_W-1:0]  m_axis_tuser
);

  logic                en;
  mi3_pkg::elem_t      a [mi3_pkg::NUM_EL];
  logic                cof_v;
  mi3_pkg::elem_t      row0 [3];
  mi3_pkg::cof_t       cof [mi3_pkg::NUM_EL];
  logic                det_v;
  mi3_pkg::cmag_t      cmag [mi3_pkg::NUM_EL];
  logic                cneg [mi3_pkg::NUM_EL];
  mi3_pkg::det_info_t  det_info;
  logic                div_v [mi3_pkg::NUM_EL];
  mi3_pkg::elem_t      qv [mi3_pkg::NUM_EL];
  logic                sat [mi3_pkg::NUM_EL];
  logic                sing [mi3_pkg::NUM_EL];

  logic [mi3_pkg::WORD_W-1:0] new_word;
  logic                       new_sat;
  logic                       new_v;
  logic [mi3_pkg::WORD_W-1:0] out_word_q, skid_word_q;
  logic                       out_sat_q, out_sing_q, skid_sat_q, skid_sing_q;
  logic                       out_v_q, skid_v_q;

  // pipeline advances while the skid register is free
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  // unpack input word
  always_comb begin
    for (int k = 0; k < mi3_pkg::NUM_EL; k++) begin
      a[k] = s_axis_tdata[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W];
    end
  end

  mi3_cofactor u_cof (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .a_i     (a),
    .valid_o (cof_v),
    .row0_o  (row0),
    .cof_o   (cof)
  );

  mi3_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cof_v),
    .row0_i  (row0),
    .cof_i   (cof),
    .valid_o (det_v),
    .cmag_o  (cmag),
    .cneg_o  (cneg),
    .det_o   (det_info)
  );

  // one divider per element; cofactor (c,r) feeds inverse element (r,c)
  for (genvar k = 0; k < mi3_pkg::NUM_EL; k++) begin : g_div
    mi3_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (det_v),
      .cmag_i  (cmag[k]),
      .cneg_i  (cneg[k]),
      .det_i   (det_info),
      .valid_o (div_v[k]),
      .q_o     (qv[k]),
      .sat_o   (sat[k]),
      .sing_o  (sing[k])
    );
  end

  // pack the finished word
  always_comb begin
    new_sat = 1'b0;
    for (int k = 0; k < mi3_pkg::NUM_EL; k++) begin
      new_word[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] = qv[k];
      new_sat = new_sat | sat[k];
    end
  end

  assign new_v = div_v[0] & en;

  // output and skid valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) skid_v_q <= 1'b0;
    end else if (new_v) begin
      if (out_v_q && !m_axis_tready) skid_v_q <= 1'b1;
      else out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready) begin
        out_word_q <= skid_word_q;
        out_sat_q  <= skid_sat_q;
        out_sing_q <= skid_sing_q;
      end
    end else if (new_v) begin
      if (out_v_q && !m_axis_tready) begin
        skid_word_q <= new_word;
        skid_sat_q  <= new_sat;
        skid_sing_q <= sing[0];
      end else begin
        out_word_q <= new_word;
        out_sat_q  <= new_sat;
        out_sing_q <= sing[0];
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = mi3_pkg::TDATA_W'(out_word_q);
  assign m_axis_tuser  = mi3_pkg::TUSER_W'({out_sat_q, out_sing_q});

endmodule

[rtl/mi3_checker.sv]
// mi3_checker: port-level checks on the matrix inverse, bound to the top level.
// Depends on mi3_pkg and matrix3x3_inverse.
`timescale 1ns / 1ps

module mi3_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [mi3_pkg::TDATA_W-1:0]  s_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [mi3_pkg::TDATA_W-1:0]  m_axis_tdata,
  input logic [mi3_pkg::TUSER_W-1:0]  m_axis_tuser
);

  // a pending result word keeps m_axis_tvalid up until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // an offered input word stays put until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input word changed while stalled");

  // singular result is all zero with no clamp flag
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
    else $error("singular word not cleared");

  // input only stalls while a result is waiting
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind matrix3x3_inverse mi3_checker u_mi3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[bench/tb_top.sv]
// tb_top: self-checking bench for matrix3x3_inverse; predicts each inverse with
// exact wide arithmetic. Depends on mi3_pkg and the matrix3x3_inverse RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int EW             = mi3_pkg::ELEM_W;
  localparam int NEL            = mi3_pkg::NUM_EL;

  typedef logic signed [255:0] big_t;
  typedef struct packed {
    logic                        saturated;
    logic                        singular;
    logic [mi3_pkg::TDATA_W-1:0] elems;
  } inverse_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [mi3_pkg::TDATA_W-1:0] s_axis_tdata;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [mi3_pkg::TDATA_W-1:0] m_axis_tdata;
  logic [mi3_pkg::TUSER_W-1:0] m_axis_tuser;

  inverse_t expected_inverses[$];
  int       mismatch_count;
  int       idle_cycles;
  int       gap_pct;       // chance of a gap between words
  int       stall_pct;     // chance the receiver holds off

  matrix3x3_inverse u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // exact inverse: cofactors, determinant, rounded quotient, clamp
  function automatic inverse_t inverse_of(logic [mi3_pkg::TDATA_W-1:0] m);
    big_t     a[3][3];
    big_t     cof[3][3];
    big_t     det, dmag, num, q, lim, val;
    bit       neg, sat;
    inverse_t res;
    res = '0;
    sat = 1'b0;
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++)
        a[r][c] = $signed(m[(c*3+r)*EW +: EW]);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        cof[r][c] = a[(r+1)%3][(c+1)%3] * a[(r+2)%3][(c+2)%3]
                  - a[(r+1)%3][(c+2)%3] * a[(r+2)%3][(c+1)%3];
    det = '0;
    for (int c = 0; c < 3; c++) det = det + a[0][c] * cof[0][c];
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    dmag = (det < 0) ? -det : det;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        num = cof[c][r] <<< (2 * mi3_pkg::FRAC_W);
        neg = (num < 0) != (det < 0);
        if (num < 0) num = -num;
        q = (2 * num + dmag) / (2 * dmag);
        if (q == 0) neg = 1'b0;
        lim = (big_t'(1) <<< (EW - 1)) - (neg ? 0 : 1);
        if (q > lim) begin
          q = lim;
          sat = 1'b1;
        end
        val = neg ? -q : q;
        res.elems[(c*3+r)*EW +: EW] = val[EW-1:0];
      end
    end
    res.saturated = sat;
    return res;
  endfunction

  // record accepted matrices, check returned inverses, watchdog
  always @(posedge clk_i) begin
    inverse_t exp_w;
    bit       moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_inverses.push_back(inverse_of(s_axis_tdata));
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (expected_inverses.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("ERROR: unexpected result word %h", m_axis_tdata);
        end else begin
          exp_w = expected_inverses.pop_front();
          for (int k = 0; k < NEL; k++)
            if (m_axis_tdata[k*EW +: EW] !== exp_w.elems[k*EW +: EW]) begin
              mismatch_count++;
              if (mismatch_count <= 10)
                $display("ERROR: element %0d expected %h got %h", k,
                         exp_w.elems[k*EW +: EW], m_axis_tdata[k*EW +: EW]);
            end
          if (m_axis_tuser[0] !== exp_w.singular || m_axis_tuser[1] !== exp_w.saturated) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("ERROR: flags expected sing=%b sat=%b got sing=%b sat=%b",
                       exp_w.singular, exp_w.saturated, m_axis_tuser[0], m_axis_tuser[1]);
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // send one matrix word; valid stays up through a burst
  task automatic send_matrix(input logic [mi3_pkg::TDATA_W-1:0] m);
    s_axis_tdata  <= m;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  function automatic logic [mi3_pkg::TDATA_W-1:0] diag(mi3_pkg::elem_t d0,
                                                       mi3_pkg::elem_t d1,
                                                       mi3_pkg::elem_t d2);
    logic [mi3_pkg::TDATA_W-1:0] m;
    m = '0;
    m[0*EW +: EW] = d0;
    m[4*EW +: EW] = d1;
    m[8*EW +: EW] = d2;
    return m;
  endfunction

  // element near unit scale, +-2.0
  function automatic mi3_pkg::elem_t scaled_elem();
    return mi3_pkg::elem_t'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
  endfunction

  function automatic logic [mi3_pkg::TDATA_W-1:0] random_matrix(int kind);
    logic [mi3_pkg::TDATA_W-1:0] m;
    for (int k = 0; k < NEL; k++)
      m[k*EW +: EW] = (kind == 0) ? mi3_pkg::elem_t'($urandom) : scaled_elem();
    if (kind == 2) m[6*EW +: 3*EW] = m[0 +: 3*EW];                   // repeated column
    if (kind == 3)                                                   // repeated row
      for (int c = 0; c < 3; c++)
        m[(c*3+2)*EW +: EW] = m[(c*3)*EW +: EW];
    if (kind == 4) m[$urandom_range(0, 2)*3*EW +: 3*EW] = '0;        // zero column
    if (kind == 5)                                                   // tiny values
      for (int k = 0; k < NEL; k++)
        m[k*EW +: EW] = mi3_pkg::elem_t'($signed($urandom_range(0, 64)) - 32);
    return m;
  endfunction

  // identity, signs, singular cases, extremes, clamping
  task automatic test_directed();
    logic [mi3_pkg::TDATA_W-1:0] m;
    gap_pct = 0;
    stall_pct = 0;
    send_matrix(diag(32'sh10000, 32'sh10000, 32'sh10000));
    send_matrix(diag(-32'sh10000, 32'sh10000, 32'sh10000));
    send_matrix(diag(32'sh20000, 32'sh40000, -32'sh8000));
    send_matrix(diag(32'sh30000, 32'sh30000, 32'sh70000));
    send_matrix('0);
    send_matrix({NEL{32'h7FFFFFFF}});
    send_matrix({NEL{32'h80000000}});
    send_matrix(diag(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    send_matrix(diag(32'h80000000, 32'h80000000, 32'h80000000));
    send_matrix(diag(32'h80000000, 32'h7FFFFFFF, 32'h80000000));
    send_matrix(diag(1, 1, 1));
    send_matrix(diag(-1, 1, 1));
    send_matrix(diag(2, 32'sh10000, 32'sh10000));
    send_matrix(diag(32'sh10000, 32'sh10000, 3));
    send_matrix({NEL{32'hFFFFFFFF}});
    m = diag(32'sh10000, 32'sh10000, 32'sh10000);
    m[3*EW +: EW] = 32'h7FFFFFFF;
    m[7*EW +: EW] = 32'h80000000;
    send_matrix(m);
    for (int kind = 0; kind < 6; kind++) send_matrix(random_matrix(kind));
  endtask

  task automatic test_random_full(int n);
    gap_pct = 20;
    stall_pct = 25;
    for (int i = 0; i < n; i++) send_matrix(random_matrix(0));
  endtask

  task automatic test_random_scaled(int n);
    gap_pct = 10;
    stall_pct = 40;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) stall_pct = 0;
      send_matrix(random_matrix($urandom_range(0, 9) < 7 ? 1 : 5));
    end
  endtask

  task automatic test_singular_mix(int n);
    gap_pct = 30;
    stall_pct = 60;
    for (int i = 0; i < n; i++) send_matrix(random_matrix($urandom_range(1, 5)));
  endtask

  task automatic test_back_to_back(int n);
    gap_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < n; i++) send_matrix(random_matrix($urandom_range(0, 5)));
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    mismatch_count = 0;
    idle_cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_full(600);
    test_random_scaled(600);
    test_singular_mix(300);
    test_back_to_back(330);
    s_axis_tvalid <= 1'b0;

    stall_pct = 20;
    while (expected_inverses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_inverses.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
